[design/rit_pkg.sv]
`default_nettype none

package rit_pkg;

    localparam int unsigned ID_W       = 16;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned HIT_W      = 8;
    localparam int unsigned SUM_W      = 25;
    localparam int unsigned TOTAL_W    = 9;
    localparam int unsigned MEAN_W     = 24;
    localparam int unsigned FRAC_W     = 8;
    localparam int unsigned DIVIDEND_W = SUM_W + FRAC_W;

    localparam logic [CNT_W-1:0]  CNT_MAX      = 8'd255;
    localparam logic [HIT_W-1:0]  HIT_MAX      = 8'd255;
    localparam logic [SUM_W-1:0]  SUM_MAX      = 25'h1FF_FFFF;
    localparam logic [MEAN_W-1:0] MEAN_MAX     = 24'hFF_FFFF;
    localparam logic [7:0]        THRESH_RESET = 8'd3;

    typedef struct packed {
        logic [ID_W-1:0] ident_number;
        logic            last_in_scan;
    } t_item;

    typedef struct packed {
        logic              was_hit;
        logic              became_valid;
        logic              stats_valid;
        logic [CNT_W-1:0]  even_count;
        logic [CNT_W-1:0]  odd_count;
        logic [MEAN_W-1:0] mean_ident;
    } t_result;

    typedef struct packed {
        logic [ID_W-1:0]  key;
        logic [HIT_W-1:0] hits;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_MISS,
        ST_WAIT
    } t_state;

endpackage

`default_nettype wire

[design/rit_list_ram.sv]
`default_nettype none

module rit_list_ram
    import rit_pkg::*;
#(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned IDX_W = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire t_entry           i_wdata,
    input  wire logic             i_re,
    input  wire logic [IDX_W-1:0] i_raddr,
    output t_entry                o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/rit_divider.sv]
`default_nettype none

module rit_divider
    import rit_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [TOTAL_W-1:0]    i_divisor,
    output logic                       o_busy,
    output logic [MEAN_W-1:0]          o_quot
);

    localparam int unsigned CNT_BITS = $clog2(DIVIDEND_W + 1);

    logic                  r_run;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [TOTAL_W-1:0]    r_rem;
    logic [TOTAL_W-1:0]    r_div;
    logic [DIVIDEND_W-1:0] r_work;

    logic [TOTAL_W:0]      trial;
    logic                  ge;
    logic [TOTAL_W:0]      diff;

    // Restoring division, one quotient bit a cycle. The dividend shifts out
    // of the top of r_work while quotient bits shift in at the bottom.
    always_comb begin
        trial = {r_rem, r_work[DIVIDEND_W-1]};
        ge    = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_cnt <= CNT_BITS'(DIVIDEND_W);
        end else if (r_run) begin
            r_cnt <= r_cnt - CNT_BITS'(1);
            if (r_cnt == CNT_BITS'(1)) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_work <= i_dividend;
        end else if (r_run) begin
            r_rem  <= ge ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
            r_work <= {r_work[DIVIDEND_W-2:0], ge};
        end
    end

    assign o_busy = r_run;
    assign o_quot = (|r_work[DIVIDEND_W-1:MEAN_W]) ? MEAN_MAX : r_work[MEAN_W-1:0];

endmodule

`default_nettype wire

[design/recent_id_tracker_with_hit_counts.sv]
`default_nettype none

// Recent identifier tracker with hit counts and per-scan statistics.
// Input: a word (identifier and end-of-scan flag) on i_item is taken at a
// rising edge where start is high and busy is low. Configuration: the hit
// threshold is written through i_cfg_we / i_cfg_wdata, by the user only while
// the block is idle; the block itself does not enforce this. Output: one
// result word per input word on o_result, present for exactly one cycle and
// marked by o_result_strobe; the receiver cannot stall it. The list lives in
// a single-port-read RAM with a registered read and is searched one entry at
// a time (read, then compare). A hit ends the search at the matching entry;
// a miss searches every occupied entry and then writes the new one. On the
// last word of a scan the mean is formed by a bit-serial divider of 33 steps
// started at acceptance, and the result waits until the divider is done.
// busy stays high until the cycle of the strobe, and a new word may be
// accepted in that cycle. Reset empties the list, clears the scan counters
// and sets the threshold to 3; the list RAM itself is not cleared.
module recent_id_tracker_with_hit_counts
    import rit_pkg::*;
#(
    parameter int unsigned LIST_DEPTH = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_item      i_item,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    output logic            o_result_strobe,
    output t_result         o_result
);

    localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int unsigned OCC_W = $clog2(LIST_DEPTH + 1);

    t_state               r_state, n_state;
    logic [7:0]           r_threshold;
    logic [ID_W-1:0]      r_id;
    logic                 r_last;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [IDX_W-1:0]     r_wp, n_wp;
    logic [OCC_W-1:0]     r_occ, n_occ;
    logic                 r_hit, n_hit;
    logic                 r_pulse, n_pulse;
    logic [CNT_W-1:0]     r_even, r_odd;
    logic [SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]     r_rep_even, r_rep_odd;
    logic                 r_strobe;
    t_result              r_result;

    logic                 accept;
    logic [CNT_W-1:0]     even_new, odd_new;
    logic [SUM_W:0]       sum_wide;
    logic [SUM_W-1:0]     sum_new;
    logic [TOTAL_W-1:0]   total_new;

    logic                 ram_we, ram_re;
    logic [IDX_W-1:0]     ram_waddr;
    t_entry               ram_wdata, ram_rdata;
    logic [HIT_W-1:0]     hits_inc;

    logic                 div_busy;
    logic [MEAN_W-1:0]    div_quot;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    // Scan statistics as they stand once the incoming word is counted.
    always_comb begin
        even_new  = r_even;
        odd_new   = r_odd;
        if (i_item.ident_number[0]) begin
            if (r_odd != CNT_MAX) odd_new = r_odd + CNT_W'(1);
        end else begin
            if (r_even != CNT_MAX) even_new = r_even + CNT_W'(1);
        end
        sum_wide  = {1'b0, r_sum} + (SUM_W + 1)'(i_item.ident_number);
        sum_new   = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];
        total_new = TOTAL_W'(even_new) + TOTAL_W'(odd_new);
    end

    rit_list_ram #(
        .DEPTH (LIST_DEPTH),
        .IDX_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    rit_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && i_item.last_in_scan),
        .i_dividend ({sum_new, FRAC_W'(0)}),
        .i_divisor  (total_new),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    assign hits_inc = ram_rdata.hits + HIT_W'(1);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_wp      = r_wp;
        n_occ     = r_occ;
        n_hit     = r_hit;
        n_pulse   = r_pulse;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '{key: r_id, hits: HIT_W'(1)};
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_pulse = 1'b0;
                    n_state = (r_occ == '0) ? ST_MISS : ST_READ;
                end
            end
            ST_READ: begin
                ram_re  = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (ram_rdata.key == r_id) begin
                    n_hit   = 1'b1;
                    n_state = ST_WAIT;
                    if (ram_rdata.hits != HIT_MAX) begin
                        ram_we    = 1'b1;
                        ram_wdata = '{key: r_id, hits: hits_inc};
                        n_pulse   = (hits_inc == r_threshold);
                    end
                end else if ((OCC_W'(r_idx) + OCC_W'(1)) == r_occ) begin
                    n_state = ST_MISS;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = ST_READ;
                end
            end
            ST_MISS: begin
                // Entries are written round robin, so the write pointer
                // always rests on the oldest entry once the list is full.
                ram_we    = 1'b1;
                ram_waddr = r_wp;
                n_wp      = (r_wp == IDX_W'(LIST_DEPTH - 1)) ? '0 : r_wp + IDX_W'(1);
                if (r_occ != OCC_W'(LIST_DEPTH)) n_occ = r_occ + OCC_W'(1);
                n_state   = ST_WAIT;
            end
            ST_WAIT: begin
                if (!div_busy) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_threshold <= THRESH_RESET;
            r_wp        <= '0;
            r_occ       <= '0;
            r_even      <= '0;
            r_odd       <= '0;
            r_sum       <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wp     <= n_wp;
            r_occ    <= n_occ;
            r_strobe <= (r_state == ST_WAIT) && !div_busy;
            if (i_cfg_we) r_threshold <= i_cfg_wdata;
            if (accept) begin
                if (i_item.last_in_scan) begin
                    r_even <= '0;
                    r_odd  <= '0;
                    r_sum  <= '0;
                end else begin
                    r_even <= even_new;
                    r_odd  <= odd_new;
                    r_sum  <= sum_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_hit   <= n_hit;
        r_pulse <= n_pulse;
        if (accept) begin
            r_id       <= i_item.ident_number;
            r_last     <= i_item.last_in_scan;
            r_rep_even <= even_new;
            r_rep_odd  <= odd_new;
        end
        if ((r_state == ST_WAIT) && !div_busy) begin
            r_result.was_hit      <= r_hit;
            r_result.became_valid <= r_pulse;
            r_result.stats_valid  <= r_last;
            r_result.even_count   <= r_last ? r_rep_even : '0;
            r_result.odd_count    <= r_last ? r_rep_odd : '0;
            r_result.mean_ident   <= r_last ? div_quot : '0;
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

    a_strobe_after_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(r_state == ST_WAIT))
        else $error("result strobe without a finished item");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(LIST_DEPTH))
        else $error("list occupancy beyond depth");

    a_pulse_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && o_result.became_valid |-> o_result.was_hit)
        else $error("threshold pulse on a miss");

    a_no_stats_mid_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && !o_result.stats_valid |->
            (o_result.mean_ident == '0) && (o_result.even_count == '0)
            && (o_result.odd_count == '0))
        else $error("statistics given before end of scan");

    a_ram_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("list RAM read and written in one cycle");

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
    import rit_pkg::*;

    localparam int unsigned LIST_DEPTH = 8;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct {
        t_item word;
        bit    drain_first;
    } t_pending;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_item       i_item = '0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = '0;
    logic        o_result_strobe;
    t_result     o_result;

    t_pending    observations_pending[$];
    t_result     reports_due[$];
    logic        took_word = 1'b0;
    int unsigned gap_pct = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // Our own copy of the tracker state.
    t_entry      list_model[LIST_DEPTH];
    int unsigned list_fill;
    logic [7:0]  threshold_model;
    logic [7:0]  scan_even_cnt;
    logic [7:0]  scan_odd_cnt;
    logic [24:0] scan_id_sum;

    logic [15:0] hot_ids[6];
    logic [15:0] cold_ids[8];

    recent_id_tracker_with_hit_counts #(
        .LIST_DEPTH(LIST_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_strobe(o_result_strobe),
        .o_result       (o_result)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic track_ident(input t_item w, output t_result r);
        int          pos;
        bit          found;
        logic [25:0] wide_sum;
        logic [8:0]  total;
        logic [32:0] quotient;
        r = '0;
        if (w.ident_number[0]) begin
            if (scan_odd_cnt != CNT_MAX) scan_odd_cnt++;
        end else begin
            if (scan_even_cnt != CNT_MAX) scan_even_cnt++;
        end
        wide_sum = scan_id_sum + w.ident_number;
        scan_id_sum = (wide_sum > SUM_MAX) ? SUM_MAX : wide_sum[24:0];

        // The whole occupied part of the list is searched; a hit stays in place.
        found = 1'b0;
        for (pos = 0; pos < int'(list_fill); pos++) begin
            if (!found && list_model[pos].key == w.ident_number) begin
                found = 1'b1;
                if (list_model[pos].hits != HIT_MAX) begin
                    list_model[pos].hits++;
                    if (list_model[pos].hits == threshold_model) r.became_valid = 1'b1;
                end
            end
        end
        if (!found) begin
            for (pos = (list_fill == LIST_DEPTH) ? LIST_DEPTH - 1 : list_fill; pos > 0; pos--)
                list_model[pos] = list_model[pos-1];
            list_model[0].key = w.ident_number;
            list_model[0].hits = 8'd1;
            if (list_fill < LIST_DEPTH) list_fill++;
        end
        r.was_hit = found;

        if (w.last_in_scan) begin
            total = scan_even_cnt + scan_odd_cnt;
            quotient = {scan_id_sum, 8'h00} / total;
            r.stats_valid = 1'b1;
            r.even_count = scan_even_cnt;
            r.odd_count = scan_odd_cnt;
            r.mean_ident = (quotient > MEAN_MAX) ? MEAN_MAX : quotient[23:0];
            scan_even_cnt = '0;
            scan_odd_cnt = '0;
            scan_id_sum = '0;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result fresh;
        if (!i_rst_n) begin
            list_fill = 0;
            threshold_model = THRESH_RESET;
            scan_even_cnt = '0;
            scan_odd_cnt = '0;
            scan_id_sum = '0;
            took_word <= 1'b0;
        end else begin
            if (i_cfg_we) threshold_model = i_cfg_wdata;
            if (o_result_strobe) begin
                if (reports_due.size() == 0) begin
                    $error("result word with no expectation waiting");
                    error_count++;
                end else begin
                    want = reports_due.pop_front();
                    check_field("was_hit", want.was_hit, o_result.was_hit);
                    check_field("became_valid", want.became_valid, o_result.became_valid);
                    check_field("stats_valid", want.stats_valid, o_result.stats_valid);
                    check_field("even_count", want.even_count, o_result.even_count);
                    check_field("odd_count", want.odd_count, o_result.odd_count);
                    check_field("mean_ident", want.mean_ident, o_result.mean_ident);
                end
            end
            if (start && !busy) begin
                track_ident(i_item, fresh);
                reports_due = {reports_due, fresh};
            end
            took_word <= start && !busy;
        end
    end

    always @(negedge i_clk) begin : driver
        bit       present;
        t_pending nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took_word) begin
            present = 1'b0;
            if (observations_pending.size() != 0 && $urandom_range(99) >= gap_pct) begin
                // A marked word waits until every earlier result has come out.
                if (!(observations_pending[0].drain_first && reports_due.size() != 0))
                    present = 1'b1;
            end
            if (present) begin
                nxt = observations_pending.pop_front();
                i_item <= nxt.word;
            end
            start <= present;
        end
    end

    task automatic add_word(input logic [15:0] ident, input bit last, input bit drain);
        t_pending p;
        p.word.ident_number = ident;
        p.word.last_in_scan = last;
        p.drain_first = drain;
        observations_pending = {observations_pending, p};
    endtask

    // Idleness is judged at a rising edge, where start and the queues are
    // settled, and the task returns on the following falling edge.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (observations_pending.size() != 0 || start || reports_due.size() != 0);
        @(negedge i_clk);
    endtask

    task automatic set_threshold(input logic [7:0] value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic draw_pools();
        foreach (hot_ids[k]) hot_ids[k] = 16'($urandom);
        foreach (cold_ids[k]) cold_ids[k] = 16'($urandom);
    endtask

    function automatic logic [15:0] pick_ident();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60) return hot_ids[$urandom_range(5)];
        if (roll < 78) return cold_ids[$urandom_range(7)];
        if (roll < 82) return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
        return 16'($urandom);
    endfunction

    task automatic queue_random_scans(input int unsigned n_words);
        int unsigned queued;
        int unsigned len;
        queued = 0;
        while (queued < n_words) begin
            len = ($urandom_range(15) == 0) ? 1 : $urandom_range(1, 16);
            if (len > n_words - queued) len = n_words - queued;
            for (int unsigned k = 0; k < len; k++)
                add_word(pick_ident(), k == len - 1, $urandom_range(99) == 0);
            queued += len;
        end
    endtask

    // One long scan over two identifiers: the hit counts reach and hold at
    // their ceiling, and both scan counters saturate.
    task automatic queue_long_scan(input int unsigned len);
        logic [15:0] even_id;
        logic [15:0] odd_id;
        even_id = {15'($urandom), 1'b0};
        odd_id = {15'($urandom), 1'b1};
        for (int unsigned k = 0; k < len; k++)
            add_word(($urandom_range(1) != 0) ? odd_id : even_id, k == len - 1, 1'b0);
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct = 20;
        draw_pools();

        // With a threshold of one, neither a miss nor a hit gives a pulse.
        set_threshold(8'd1);
        add_word(16'h0000, 1'b0, 1'b0);
        add_word(16'h0000, 1'b0, 1'b0);
        add_word(16'hFFFF, 1'b1, 1'b0);

        set_threshold(8'd2);
        add_word(16'h0001, 1'b0, 1'b0);
        add_word(16'h0001, 1'b0, 1'b0);
        add_word(16'h0001, 1'b0, 1'b0);
        for (int unsigned k = 2; k <= 8; k++)
            add_word(16'(k), 1'b0, 1'b0);
        // The list is now full and 0x0001 sits in its deepest place.
        add_word(16'h0001, 1'b0, 1'b0);
        add_word(16'h0000, 1'b0, 1'b1);
        add_word(16'h0001, 1'b1, 1'b0);
        add_word(16'h8000, 1'b1, 1'b0);
        add_word(16'hAAAA, 1'b0, 1'b0);
        add_word(16'h5555, 1'b1, 1'b0);

        set_threshold(8'd0);
        queue_random_scans(620);

        set_threshold(8'd255);
        gap_pct = 77;
        draw_pools();
        queue_long_scan(540);
        queue_random_scans(100);

        set_threshold(8'($urandom_range(3, 254)));
        gap_pct = 0;
        draw_pools();
        queue_random_scans(600);

        wait_idle();
        repeat (40) @(negedge i_clk);
        if (error_count == 0 && reports_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
